[hw/rtl/srpt_per_flow_scheduler_defines.svh]
// Assertion macros shared by the scheduler RTL.
// Included by modules that carry concurrent checks; SYNTH strips them.
`ifndef SRPT_PER_FLOW_SCHEDULER_DEFINES_SVH
`define SRPT_PER_FLOW_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define SRPT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("srpt check failed");
`define SRPT_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("srpt check failed");
`else
`define SRPT_ASSERT(lbl, clk, rst, prop)
`define SRPT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[hw/rtl/srpt_pkg.sv]
// Shared types and constants for the per-flow SRPT scheduler.
// No dependencies.
package srpt_pkg;
  localparam int FLOWS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PRIO_BITS_DEF = 16;
  localparam int FLOW_W = 4;
  localparam int FIELD_W = 16;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ = 2'd0, ST_DROP = 2'd1, ST_DEQ = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic func;
    logic [FLOW_W-1:0] flow_id;
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] packet_tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [FLOW_W-1:0] out_flow_id;
    logic [FIELD_W-1:0] out_prio;
    logic [FIELD_W-1:0] out_tag;
  } result_t;
endpackage

[hw/rtl/srpt_per_flow_scheduler.sv]
// Per-flow SRPT packet scheduler: with the back end idle, an enqueue is handled
// in S_IDLE and answered with a registered done; a dequeue first scans the
// head-priority table one flow per cycle (S_READ), answers from S_SEL, and the
// back end then reads the store to refresh the popped flow's head in S_REFILL,
// unless that flow is now empty. One result strobe (done) per command; the receiver cannot stall,
// and a two-entry command queue lets start be taken while the back end works.
// Depends on srpt_pkg, srpt_front and srpt_back.
module srpt_per_flow_scheduler #(
  parameter int FLOWS = srpt_pkg::FLOWS_DEF,
  parameter int QUEUE_DEPTH = srpt_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIO_BITS = srpt_pkg::PRIO_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  srpt_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output srpt_pkg::result_t result
);
  import srpt_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  srpt_front u_front (
    .clk, .rst, .start, .cmd, .busy, .q_valid, .q_cmd, .q_pop
  );

  srpt_back #(.FLOWS(FLOWS), .QUEUE_DEPTH(QUEUE_DEPTH), .PRIO_BITS(PRIO_BITS)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .done, .result
  );
endmodule

[hw/rtl/srpt_front.sv]
// Front end: takes commands and queues them for the back end.
// Depends on srpt_pkg and srpt_per_flow_scheduler_defines.svh.
module srpt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  srpt_pkg::cmd_t cmd,
  output logic           busy,
  output logic           q_valid,
  output srpt_pkg::cmd_t q_cmd,
  input  logic           q_pop
);
  import srpt_pkg::*;
  `include "srpt_per_flow_scheduler_defines.svh"

  // two-entry queue
  cmd_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `SRPT_ASSERT(a_no_pop_empty, clk, rst, q_pop |-> q_valid)
  `SRPT_ASSERT(a_count_max, clk, rst, count != 2'd3)
  `SRPT_ASSERT(a_count_step, clk, rst, (push && !q_pop) |=> count == $past(count) + 2'd1)
endmodule

[hw/rtl/srpt_back.sv]
// Back end: per-flow FIFO storage, head-priority table and min select.
// Depends on srpt_pkg and srpt_per_flow_scheduler_defines.svh.
module srpt_back #(
  parameter int FLOWS = srpt_pkg::FLOWS_DEF,
  parameter int QUEUE_DEPTH = srpt_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIO_BITS = srpt_pkg::PRIO_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  srpt_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              done,
  output srpt_pkg::result_t result
);
  import srpt_pkg::*;
  `include "srpt_per_flow_scheduler_defines.svh"

  localparam int FI_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int SL_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (PRIO_BITS < FIELD_W) ? PRIO_BITS : FIELD_W;
  localparam int ADDR_W = FI_W + SL_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [SL_W-1:0] LAST_SLOT = SL_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [PW-1:0] prio;
    logic [FIELD_W-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_SEL, S_READ, S_REFILL} state_t;

  // each flow owns a power-of-two block of slots
  entry_t mem [FLOWS << SL_W];
  entry_t rd_data;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic wr_en, rd_en;

  logic [SL_W-1:0] head [FLOWS];
  logic [SL_W-1:0] tail [FLOWS];
  logic [CNT_W-1:0] fill [FLOWS];
  logic [PW-1:0] head_prio [FLOWS];

  state_t state;
  logic [FI_W-1:0] best;
  logic [FI_W-1:0] scan;
  logic found;
  logic [PW-1:0] best_prio;

  logic [PW-1:0] in_prio;
  logic [FI_W-1:0] in_flow;
  logic flow_ok;

  assign in_prio = q_cmd.prio[PW-1:0];
  assign in_flow = FI_W'(q_cmd.flow_id);
  assign flow_ok = (32'(q_cmd.flow_id) < FLOWS);

  // Memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= '{prio: in_prio, tag: q_cmd.packet_tag};
    if (rd_en) rd_data <= mem[rd_addr];
  end

  function automatic logic [SL_W-1:0] nxt(input logic [SL_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SL_W'(1);
  endfunction

  logic enq_go, enq_ok;
  assign enq_go = (state == S_IDLE) && q_valid && (q_cmd.func == FUNC_ENQ);
  assign enq_ok = enq_go && flow_ok && (fill[in_flow] != DEPTH_C);
  assign wr_en = enq_ok;
  assign wr_addr = {in_flow, tail[in_flow]};

  // After a pop, read the new head of the chosen flow to refresh its prio
  logic [SL_W-1:0] new_head;
  assign new_head = nxt(head[best]);
  assign rd_en = (state == S_SEL) && found;
  assign rd_addr = {best, new_head};

  always_comb begin
    q_pop = 1'b0;
    unique case (state)
      S_IDLE: q_pop = enq_go;
      S_SEL: q_pop = 1'b1;
      default: q_pop = 1'b0;
    endcase
  end

  // Tag of each flow head kept beside its prio
  logic [FIELD_W-1:0] head_tag [FLOWS];
  logic [FIELD_W-1:0] mem_tag_q;
  assign mem_tag_q = head_tag[best];
  always_ff @(posedge clk) begin
    if (enq_ok && fill[in_flow] == '0) head_tag[in_flow] <= q_cmd.packet_tag;
    if (state == S_REFILL) head_tag[best] <= rd_data.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      scan <= '0;
      found <= 1'b0;
      for (int i = 0; i < FLOWS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      done <= enq_go || (state == S_SEL);
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_cmd.func == FUNC_ENQ) begin
            result <= '{status: (enq_ok ? ST_ENQ : ST_DROP), default: '0};
            if (enq_ok) begin
              tail[in_flow] <= nxt(tail[in_flow]);
              fill[in_flow] <= fill[in_flow] + CNT_W'(1);
              // first packet of a flow becomes its head
              if (fill[in_flow] == '0) head_prio[in_flow] <= in_prio;
            end
          end else if (q_valid) begin
            // scan flows one per cycle for the smallest head prio
            state <= S_READ;
            scan <= '0;
            found <= 1'b0;
          end
        end
        S_SEL: begin
          // pop the winner and answer, or report nothing queued
          if (found) begin
            result <= '{status: ST_DEQ, out_flow_id: FLOW_W'(best),
                        out_prio: FIELD_W'(best_prio), out_tag: mem_tag_q};
            head[best] <= new_head;
            fill[best] <= fill[best] - CNT_W'(1);
            state <= (fill[best] == CNT_W'(1)) ? S_IDLE : S_REFILL;
          end else begin
            result <= '{status: ST_EMPTY, default: '0};
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (fill[scan] != '0 && (!found || head_prio[scan] < best_prio)) begin
            found <= 1'b1;
            best <= scan;
            best_prio <= head_prio[scan];
          end
          if (32'(scan) == FLOWS - 1) state <= S_SEL;
          else scan <= scan + FI_W'(1);
        end
        default: begin
          head_prio[best] <= rd_data.prio;
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SRPT_ASSERT(a_done_pop, clk, rst, done |-> $past(q_pop))
  `SRPT_ASSERT(a_fill_range, clk, rst, fill[0] <= DEPTH_C)
  `SRPT_ASSERT(a_sel_done, clk, rst, state == S_SEL |=> done)
endmodule
